// ----- rtl/r2p_pkg.sv -----
`timescale 1ns / 1ps

package r2p_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MAG_BITS      = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int MAX_STAGES    = 32;

  // Datapath: 16 fraction guard bits on x/y, headroom for pre-rotation and CORDIC gain.
  localparam int GUARD_BITS = 16;
  localparam int XW         = COORD_BITS + GUARD_BITS + 3;
  // Angle accumulator, Q2.30 radians with headroom for the accumulated sum.
  localparam int Z_FRAC = 30;
  localparam int ZW     = Z_FRAC + 4;

  localparam int HALF_PI_Q30  = 1686629713;
  localparam int INV_GAIN_W   = 30;
  localparam int INV_GAIN_Q30 = 652032874;
  localparam int GAIN_FRAC    = 30;
  localparam int DEG_K_W      = 22;
  localparam int DEG_K_Q16    = 3754936;
  localparam int RAD_SHIFT    = 17;
  localparam int DEG_SHIFT    = 39;
  localparam int RAD_LIMIT    = 25736;
  localparam int DEG_LIMIT    = 23040;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
  } r2p_coord_t;

  typedef struct packed {
    logic        [MAG_BITS-1:0]   magnitude;
    logic signed [ANGLE_BITS-1:0] angle;
  } r2p_polar_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } r2p_vec_t;

  // atan(2^-i) in Q2.30, rounded
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    case (idx)
      0:  return ZW'(843314857);
      1:  return ZW'(497837829);
      2:  return ZW'(263043837);
      3:  return ZW'(133525159);
      4:  return ZW'(67021687);
      5:  return ZW'(33543516);
      6:  return ZW'(16775851);
      7:  return ZW'(8388437);
      8:  return ZW'(4194283);
      9:  return ZW'(2097149);
      10: return ZW'(1048576);
      11: return ZW'(524288);
      12: return ZW'(262144);
      13: return ZW'(131072);
      14: return ZW'(65536);
      15: return ZW'(32768);
      16: return ZW'(16384);
      17: return ZW'(8192);
      18: return ZW'(4096);
      19: return ZW'(2048);
      20: return ZW'(1024);
      21: return ZW'(512);
      22: return ZW'(256);
      23: return ZW'(128);
      24: return ZW'(64);
      25: return ZW'(32);
      26: return ZW'(16);
      27: return ZW'(8);
      28: return ZW'(4);
      29: return ZW'(2);
      30: return ZW'(1);
      default: return '0;
    endcase
  endfunction

endpackage

// ----- rtl/rect_to_polar_converter.sv -----
`timescale 1ns / 1ps

// Cartesian to polar converter, pipelined CORDIC vectoring.
// coord channel (valid/ready) takes one word {x_coord, y_coord} per cycle while coord_ready is high.
// polar channel (valid/ready) gives {magnitude, angle} in input order.
// angle is radians Q3.13, or degrees Q9.7 when angle_in_degrees (APB reg 0)
// is set; zero vector gives magnitude 0, angle 0.
// Pipeline: pre-rotation, one register stage per micro-rotation, two stages
// for gain/unit multiply and rounding, output register. Throughput: one
// word per cycle while the receiver takes results.
// Each stage holds while the one after it is full and stalled, so a stalled
// receiver fills the pipe's bubbles before coord_ready drops; nothing is
// dropped or repeated.
// Reset (rst, synchronous) empties the pipe and clears angle_in_degrees.
// Write the register only while the pipe is empty.
module rect_to_polar_converter #(
  parameter int CORDIC_STAGES = r2p_pkg::CORDIC_STAGES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                coord_valid,
  output logic                coord_ready,
  input  r2p_pkg::r2p_coord_t coord,
  output logic                polar_valid,
  input  logic                polar_ready,
  output r2p_pkg::r2p_polar_t polar,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import r2p_pkg::*;

  localparam int N_ROT = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  localparam int UX_HI_W = XW - 1 - GUARD_BITS;
  localparam int MH_W    = UX_HI_W + INV_GAIN_W;
  localparam int ML_W    = GUARD_BITS + INV_GAIN_W;
  localparam int PROD_W  = MH_W + 1;
  localparam int MAG_W   = PROD_W - GAIN_FRAC;
  localparam int ZH_W    = ZW - RAD_SHIFT;
  localparam int PH_W    = ZH_W + DEG_K_W + 1;
  localparam int PL_W    = RAD_SHIFT + DEG_K_W;
  localparam int P_W     = PH_W + RAD_SHIFT + 1;
  localparam int DEG_W   = P_W - DEG_SHIFT;
  localparam int RAD_W   = ZW + 1 - RAD_SHIFT;

  localparam logic [0:0] CFG_ANGLE_IN_DEGREES = 1'b0;

  localparam logic        [INV_GAIN_W-1:0] INV_GAIN  = INV_GAIN_W'(INV_GAIN_Q30);
  localparam logic        [DEG_K_W-1:0]    DEG_K_U   = DEG_K_W'(DEG_K_Q16);
  localparam logic signed [DEG_K_W:0]      DEG_K_S   = {1'b0, DEG_K_U};
  localparam logic signed [ZW-1:0]         HALF_PI   = ZW'(HALF_PI_Q30);
  localparam logic        [PROD_W-1:0]     MAG_ROUND = PROD_W'(1) << (GAIN_FRAC - 1);
  localparam logic        [P_W-1:0]        DEG_ROUND = P_W'(1) << (DEG_SHIFT - 1);
  localparam logic signed [ZW:0]           RAD_ROUND = (ZW+1)'(1) <<< (RAD_SHIFT - 1);
  localparam logic signed [RAD_W-1:0]      RAD_HI    = RAD_W'(RAD_LIMIT);
  localparam logic signed [RAD_W-1:0]      RAD_LO    = -RAD_HI;
  localparam logic signed [DEG_W-1:0]      DEG_HI    = DEG_W'(DEG_LIMIT);
  localparam logic signed [DEG_W-1:0]      DEG_LO    = -DEG_HI;
  localparam logic        [MAG_W-1:0]      MAG_MAX   = {{(MAG_W-MAG_BITS){1'b0}}, {MAG_BITS{1'b1}}};

  // config register
  logic angle_in_degrees;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == CFG_ANGLE_IN_DEGREES) ? {31'd0, angle_in_degrees} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_in_degrees <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2:2] == CFG_ANGLE_IN_DEGREES) begin
      angle_in_degrees <= pwdata[0];
    end
  end

  // stage advance chain
  logic [N_ROT:0] rv, adv;
  r2p_vec_t       vec [0:N_ROT];
  logic           adv_m1, adv_m2, adv_out;
  logic           m1_valid, m2_valid;

  assign adv_out     = !polar_valid || polar_ready;
  assign adv_m2      = !m2_valid || adv_out;
  assign adv_m1      = !m1_valid || adv_m2;
  assign adv[N_ROT]  = !rv[N_ROT] || adv_m1;
  assign coord_ready = adv[0];

  // pre-rotation into the right half plane
  logic                    pre_valid;
  r2p_vec_t                pre_vec, pre_next;
  logic signed [COORD_BITS-1:0] cx, cy;
  logic signed [XW-1:0]    gx, gy;

  assign cx = coord.x_coord;
  assign cy = coord.y_coord;
  assign gx = XW'(cx) <<< GUARD_BITS;
  assign gy = XW'(cy) <<< GUARD_BITS;

  always_comb begin
    pre_next.zero = (cx == '0) && (cy == '0);
    if (!cx[COORD_BITS-1]) begin
      pre_next.x = gx;
      pre_next.y = gy;
      pre_next.z = '0;
    end else if (!cy[COORD_BITS-1]) begin
      pre_next.x = gy;
      pre_next.y = -gx;
      pre_next.z = HALF_PI;
    end else begin
      pre_next.x = -gy;
      pre_next.y = gx;
      pre_next.z = -HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else if (adv[0]) begin
      pre_valid <= coord_valid;
    end
    if (adv[0]) begin
      pre_vec <= pre_next;
    end
  end

  assign rv[0]  = pre_valid;
  assign vec[0] = pre_vec;

  // micro-rotations
  for (genvar k = 1; k <= N_ROT; k++) begin : g_rot
    assign adv[k-1] = !rv[k-1] || adv[k];
    r2p_rot_stage #(
      .SHIFT(k - 1)
    ) u_rot (
      .clk      (clk),
      .rst      (rst),
      .en       (adv[k]),
      .in_valid (rv[k-1]),
      .in_vec   (vec[k-1]),
      .out_valid(rv[k]),
      .out_vec  (vec[k])
    );
  end

  // M1: gain and unit-conversion products, radians result
  logic        [XW-2:0]      ux;
  logic        [UX_HI_W-1:0] ux_hi;
  logic        [GUARD_BITS-1:0] ux_lo;
  logic signed [ZW-1:0]      zf;
  logic signed [ZH_W-1:0]    zh;
  logic        [RAD_SHIFT-1:0] zl;
  logic signed [ZW:0]        z_rnd;
  logic signed [RAD_W-1:0]   rad_full;
  logic signed [ANGLE_BITS-1:0] rad_next;

  logic        [MH_W-1:0]    m1_mh;
  logic        [ML_W-1:0]    m1_ml;
  logic signed [PH_W-1:0]    m1_ph;
  logic        [PL_W-1:0]    m1_pl;
  logic signed [ANGLE_BITS-1:0] m1_rad;
  logic                      m1_zero;

  assign ux       = vec[N_ROT].x[XW-1] ? '0 : vec[N_ROT].x[XW-2:0];
  assign ux_hi    = ux[XW-2:GUARD_BITS];
  assign ux_lo    = ux[GUARD_BITS-1:0];
  assign zf       = vec[N_ROT].z;
  assign zh       = zf[ZW-1:RAD_SHIFT];
  assign zl       = zf[RAD_SHIFT-1:0];
  assign z_rnd    = (ZW+1)'(zf) + RAD_ROUND;
  assign rad_full = z_rnd[ZW:RAD_SHIFT];

  always_comb begin
    if (rad_full > RAD_HI) begin
      rad_next = ANGLE_BITS'(RAD_HI);
    end else if (rad_full < RAD_LO) begin
      rad_next = ANGLE_BITS'(RAD_LO);
    end else begin
      rad_next = ANGLE_BITS'(rad_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv_m1) begin
      m1_valid <= rv[N_ROT];
    end
    if (adv_m1) begin
      m1_mh   <= MH_W'(ux_hi) * MH_W'(INV_GAIN);
      m1_ml   <= ML_W'(ux_lo) * ML_W'(INV_GAIN);
      m1_ph   <= PH_W'(zh) * PH_W'(DEG_K_S);
      m1_pl   <= PL_W'(zl) * PL_W'(DEG_K_U);
      m1_rad  <= rad_next;
      m1_zero <= vec[N_ROT].zero;
    end
  end

  // M2: partial product sums with rounding offsets
  logic        [PROD_W-1:0]  m2_prod;
  logic signed [P_W-1:0]     m2_p;
  logic signed [ANGLE_BITS-1:0] m2_rad;
  logic                      m2_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv_m2) begin
      m2_valid <= m1_valid;
    end
    if (adv_m2) begin
      m2_prod <= PROD_W'(m1_mh) + PROD_W'(m1_ml[ML_W-1:GUARD_BITS]) + MAG_ROUND;
      m2_p    <= (P_W'(m1_ph) <<< RAD_SHIFT) + P_W'(m1_pl) + DEG_ROUND;
      m2_rad  <= m1_rad;
      m2_zero <= m1_zero;
    end
  end

  // output: scale down, saturate, select unit
  logic        [MAG_W-1:0]   mag_full;
  logic signed [DEG_W-1:0]   deg_full;
  logic signed [ANGLE_BITS-1:0] deg_sat;
  r2p_polar_t                polar_next;

  assign mag_full = m2_prod[PROD_W-1:GAIN_FRAC];
  assign deg_full = m2_p[P_W-1:DEG_SHIFT];

  always_comb begin
    if (deg_full > DEG_HI) begin
      deg_sat = ANGLE_BITS'(DEG_HI);
    end else if (deg_full < DEG_LO) begin
      deg_sat = ANGLE_BITS'(DEG_LO);
    end else begin
      deg_sat = ANGLE_BITS'(deg_full);
    end
    if (m2_zero) begin
      polar_next.magnitude = '0;
      polar_next.angle     = '0;
    end else begin
      polar_next.magnitude = (mag_full > MAG_MAX) ? '1 : mag_full[MAG_BITS-1:0];
      polar_next.angle     = angle_in_degrees ? deg_sat : m2_rad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      polar_valid <= 1'b0;
    end else if (adv_out) begin
      polar_valid <= m2_valid;
    end
    if (adv_out) begin
      polar <= polar_next;
    end
  end

endmodule

// ----- rtl/r2p_rot_stage.sv -----
`timescale 1ns / 1ps

module r2p_rot_stage #(
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  r2p_pkg::r2p_vec_t  in_vec,
  output logic               out_valid,
  output r2p_pkg::r2p_vec_t  out_vec
);
  import r2p_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_STEP = atan_q30(SHIFT);

  logic signed [XW-1:0] x, y, dx, dy;
  logic signed [ZW-1:0] z;
  r2p_vec_t             vec_next;

  assign x  = in_vec.x;
  assign y  = in_vec.y;
  assign z  = in_vec.z;
  assign dx = y >>> SHIFT;
  assign dy = x >>> SHIFT;

  always_comb begin
    vec_next.zero = in_vec.zero;
    if (!y[XW-1]) begin
      vec_next.x = x + dx;
      vec_next.y = y - dy;
      vec_next.z = z + ATAN_STEP;
    end else begin
      vec_next.x = x - dx;
      vec_next.y = y + dy;
      vec_next.z = z - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule
